>>> src/gb2312_font_rom_address_top_defines.svh
// Assertion helpers for the font-ROM address block.
// Both expect clk and rst_n in scope and stay quiet while reset is held.
`ifndef GB2312_FONT_ROM_ADDRESS_TOP_DEFINES_SVH
`define GB2312_FONT_ROM_ADDRESS_TOP_DEFINES_SVH

// Same-cycle implication
`define GFRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define GFRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/gfra_pkg.sv
package gfra_pkg;

  // Field widths
  localparam int unsigned ADDR_W    = 24;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned ACTION_W  = 3;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned CFG_IDX_W = 3;

  // Default ROM address width
  localparam int unsigned ADDRESS_BITS_DEF = 24;

  // Request kinds
  typedef enum logic [ACTION_W-1:0] {
    ACT_GLYPH16 = 3'd0,
    ACT_GLYPH12 = 3'd1,
    ACT_ASCII16 = 3'd2,
    ACT_ASCII12 = 3'd3,
    ACT_UNICODE = 3'd4
  } action_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GLYPH16_BASE    = 3'd0,
    CFG_GLYPH12_BASE    = 3'd1,
    CFG_ASCII16_BASE    = 3'd2,
    CFG_ASCII12_BASE    = 3'd3,
    CFG_TO_UNICODE_BASE = 3'd4
  } cfg_idx_t;

  // Table base addresses
  typedef struct packed {
    logic [ADDR_W-1:0] glyph16;
    logic [ADDR_W-1:0] glyph12;
    logic [ADDR_W-1:0] ascii16;
    logic [ADDR_W-1:0] ascii12;
    logic [ADDR_W-1:0] to_unicode;
  } bases_t;

  // One result item
  typedef struct packed {
    logic [ADDR_W-1:0]  rom_address;
    logic [COUNT_W-1:0] byte_count;
    logic               valid_res;
    logic               last;
  } res_t;

  // Code points and table offsets
  localparam logic [CODE_W-1:0] ZONE_A1    = 8'hA1;
  localparam logic [CODE_W-1:0] ZONE_A3    = 8'hA3;
  localparam logic [CODE_W-1:0] ZONE_A4    = 8'hA4;
  localparam logic [CODE_W-1:0] ZONE_A8    = 8'hA8;
  localparam logic [CODE_W-1:0] ZONE_A9    = 8'hA9;
  localparam logic [CODE_W-1:0] ZONE_B0    = 8'hB0;
  localparam logic [CODE_W-1:0] ZONE_F7    = 8'hF7;
  localparam logic [CODE_W-1:0] POS_F6     = 8'hF6;
  localparam logic [CODE_W-1:0] PRINT_LO   = 8'h20;
  localparam logic [CODE_W-1:0] PRINT_HI   = 8'h7E;
  localparam int unsigned       ROW_LEN    = 94;
  localparam int unsigned       G16_HAN    = 846;
  localparam int unsigned       G12_HAN    = 376;
  localparam int unsigned       G12_A9     = 282;
  localparam int unsigned       UNI_HAN    = 368;

  // Read lengths
  localparam logic [COUNT_W-1:0] CNT_G16 = 6'd32;
  localparam logic [COUNT_W-1:0] CNT_G12 = 6'd24;
  localparam logic [COUNT_W-1:0] CNT_A16 = 6'd16;
  localparam logic [COUNT_W-1:0] CNT_A12 = 6'd12;
  localparam logic [COUNT_W-1:0] CNT_UNI = 6'd2;
  localparam logic [COUNT_W-1:0] CNT_NONE = 6'd0;

endpackage

>>> src/gfra_cfg_regs.sv
module gfra_cfg_regs (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [gfra_pkg::CFG_IDX_W-1:0]    wr_idx,
  input  logic [gfra_pkg::ADDR_W-1:0]       wr_data,
  output gfra_pkg::bases_t                  bases
);

  gfra_pkg::bases_t bases_r;
  gfra_pkg::bases_t bases_nxt;

  // Register write decode; unknown indexes are dropped
  always_comb begin
    bases_nxt = bases_r;
    if (wr_en) begin
      unique case (gfra_pkg::cfg_idx_t'(wr_idx))
        gfra_pkg::CFG_GLYPH16_BASE:    bases_nxt.glyph16    = wr_data;
        gfra_pkg::CFG_GLYPH12_BASE:    bases_nxt.glyph12    = wr_data;
        gfra_pkg::CFG_ASCII16_BASE:    bases_nxt.ascii16    = wr_data;
        gfra_pkg::CFG_ASCII12_BASE:    bases_nxt.ascii12    = wr_data;
        gfra_pkg::CFG_TO_UNICODE_BASE: bases_nxt.to_unicode = wr_data;
        default:                       bases_nxt = bases_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bases_r <= '0;
    end else begin
      bases_r <= bases_nxt;
    end
  end

  assign bases = bases_r;

endmodule

>>> src/gfra_addr_calc.sv
module gfra_addr_calc #(
  parameter int unsigned ADDRESS_BITS = gfra_pkg::ADDRESS_BITS_DEF
) (
  input  logic [gfra_pkg::ACTION_W-1:0] action,
  input  logic [gfra_pkg::CODE_W-1:0]   code_high,
  input  logic [gfra_pkg::CODE_W-1:0]   code_low,
  input  gfra_pkg::bases_t              bases,
  output gfra_pkg::res_t                res0,
  output gfra_pkg::res_t                res1,
  output logic                          two
);

  localparam int unsigned OFF_W     = 18;
  localparam int unsigned IDX_W     = 13;
  localparam int unsigned ADDR_KEEP =
    (ADDRESS_BITS < gfra_pkg::ADDR_W) ? ADDRESS_BITS : gfra_pkg::ADDR_W;
  localparam logic [gfra_pkg::ADDR_W-1:0] ADDR_MASK =
    gfra_pkg::ADDR_W'((64'd1 << ADDR_KEEP) - 64'd1);

  // base + offset, wrapped to the ROM address width
  function automatic logic [gfra_pkg::ADDR_W-1:0] wrap_addr(
    input logic [gfra_pkg::ADDR_W-1:0] base,
    input logic [OFF_W-1:0]            off
  );
    logic [gfra_pkg::ADDR_W:0] sum;
    sum = {1'b0, base} + (gfra_pkg::ADDR_W+1)'(off);
    return sum[gfra_pkg::ADDR_W-1:0] & ADDR_MASK;
  endfunction

  function automatic gfra_pkg::res_t mk_res(
    input logic [gfra_pkg::ADDR_W-1:0]  addr,
    input logic [gfra_pkg::COUNT_W-1:0] cnt,
    input logic                         last
  );
    gfra_pkg::res_t r;
    r.rom_address = addr;
    r.byte_count  = cnt;
    r.valid_res   = 1'b1;
    r.last        = last;
    return r;
  endfunction

  function automatic logic printable(input logic [gfra_pkg::CODE_W-1:0] c);
    return (c >= gfra_pkg::PRINT_LO) && (c <= gfra_pkg::PRINT_HI);
  endfunction

  // 8x16 glyph offset of a printable byte
  function automatic logic [OFF_W-1:0] ascii16_off(input logic [gfra_pkg::CODE_W-1:0] c);
    logic [gfra_pkg::CODE_W-1:0] d;
    d = c - gfra_pkg::PRINT_LO;
    return OFF_W'({d, 4'b0000});
  endfunction

  gfra_pkg::res_t              invalid_res;
  logic                        lo_ok;
  logic [6:0]                  lo_off;
  logic [6:0]                  row_sym;
  logic [6:0]                  row_han;
  logic [IDX_W-1:0]            sym_idx;
  logic [IDX_W-1:0]            han_idx;
  logic                        hi_a1_a9;
  logic                        hi_a1_a3;
  logic                        hi_a4_a8;
  logic                        hi_a9;
  logic                        hi_han;
  logic [gfra_pkg::CODE_W-1:0] lo_rel;
  logic                        pair_ok;
  logic [IDX_W-1:0]            uni_idx;

  assign invalid_res = '{rom_address: '0, byte_count: gfra_pkg::CNT_NONE,
                         valid_res: 1'b0, last: 1'b1};

  // Zone decode and the row*94+position indexes
  assign lo_ok    = code_low >= gfra_pkg::ZONE_A1;
  assign lo_off   = 7'(code_low - gfra_pkg::ZONE_A1);
  assign row_sym  = 7'(code_high - gfra_pkg::ZONE_A1);
  assign row_han  = 7'(code_high - gfra_pkg::ZONE_B0);
  assign sym_idx  = IDX_W'(row_sym) * IDX_W'(gfra_pkg::ROW_LEN) + IDX_W'(lo_off);
  assign han_idx  = IDX_W'(row_han) * IDX_W'(gfra_pkg::ROW_LEN) + IDX_W'(lo_off);
  assign hi_a1_a9 = (code_high >= gfra_pkg::ZONE_A1) && (code_high <= gfra_pkg::ZONE_A9);
  assign hi_a1_a3 = (code_high >= gfra_pkg::ZONE_A1) && (code_high <= gfra_pkg::ZONE_A3);
  assign hi_a4_a8 = (code_high >= gfra_pkg::ZONE_A4) && (code_high <= gfra_pkg::ZONE_A8);
  assign hi_a9    = code_high == gfra_pkg::ZONE_A9;
  assign hi_han   = (code_high >= gfra_pkg::ZONE_B0) && (code_high <= gfra_pkg::ZONE_F7);
  assign lo_rel   = code_low - gfra_pkg::PRINT_LO;
  assign pair_ok  = printable(code_high) && printable(code_low);

  // Unicode table index; codes outside the zones use entry zero
  always_comb begin
    uni_idx = '0;
    if (hi_a1_a3 && lo_ok) begin
      uni_idx = sym_idx;
    end else if (hi_a9 && lo_ok && (code_low <= gfra_pkg::POS_F6)) begin
      uni_idx = IDX_W'(gfra_pkg::G12_A9) + IDX_W'(lo_off);
    end else if (hi_han && lo_ok) begin
      uni_idx = han_idx + IDX_W'(gfra_pkg::UNI_HAN);
    end
  end

  // Per-kind result selection
  always_comb begin
    logic glyph_hit;
    logic [OFF_W-1:0] off;
    glyph_hit = 1'b0;
    off  = '0;
    res0 = invalid_res;
    res1 = invalid_res;
    two  = 1'b0;
    unique case (gfra_pkg::action_t'(action))
      gfra_pkg::ACT_GLYPH16: begin
        if (hi_a4_a8 && lo_ok) begin
          glyph_hit = 1'b1;
          off = '0;
        end else if (hi_a1_a9 && lo_ok) begin
          glyph_hit = 1'b1;
          off = OFF_W'({sym_idx, 5'b00000});
        end else if (hi_han && lo_ok) begin
          glyph_hit = 1'b1;
          off = OFF_W'({han_idx + IDX_W'(gfra_pkg::G16_HAN), 5'b00000});
        end
        if (glyph_hit) begin
          res0 = mk_res(wrap_addr(bases.glyph16, off), gfra_pkg::CNT_G16, 1'b1);
        end
      end
      gfra_pkg::ACT_GLYPH12: begin
        if (hi_a1_a3 && lo_ok) begin
          glyph_hit = 1'b1;
          off = OFF_W'(sym_idx) * OFF_W'(gfra_pkg::CNT_G12);
        end else if (hi_a9 && lo_ok) begin
          glyph_hit = 1'b1;
          off = (OFF_W'(gfra_pkg::G12_A9) + OFF_W'(lo_off)) * OFF_W'(gfra_pkg::CNT_G12);
        end else if (hi_han && lo_ok) begin
          glyph_hit = 1'b1;
          off = (OFF_W'(han_idx) + OFF_W'(gfra_pkg::G12_HAN)) * OFF_W'(gfra_pkg::CNT_G12);
        end
        if (glyph_hit) begin
          res0 = mk_res(wrap_addr(bases.glyph12, off), gfra_pkg::CNT_G12, 1'b1);
        end
      end
      gfra_pkg::ACT_ASCII16: begin
        if (printable(code_low)) begin
          res0 = mk_res(wrap_addr(bases.ascii16, ascii16_off(code_low)),
                        gfra_pkg::CNT_A16, 1'b1);
        end
      end
      gfra_pkg::ACT_ASCII12: begin
        if (printable(code_low)) begin
          off  = OFF_W'(lo_rel) * OFF_W'(gfra_pkg::CNT_A12);
          res0 = mk_res(wrap_addr(bases.ascii12, off), gfra_pkg::CNT_A12, 1'b1);
        end
      end
      gfra_pkg::ACT_UNICODE: begin
        off  = OFF_W'({uni_idx, 1'b0});
        res0 = mk_res(wrap_addr(bases.to_unicode, off), gfra_pkg::CNT_UNI, 1'b1);
      end
      default: begin
        res0 = invalid_res;
      end
    endcase

    // Unmapped GB2312 code: one 8x16 glyph per byte if both bytes are printable, else invalid
    if (((gfra_pkg::action_t'(action) == gfra_pkg::ACT_GLYPH16) ||
         (gfra_pkg::action_t'(action) == gfra_pkg::ACT_GLYPH12)) && !glyph_hit) begin
      if (pair_ok) begin
        two  = 1'b1;
        res0 = mk_res(wrap_addr(bases.ascii16, ascii16_off(code_high)),
                      gfra_pkg::CNT_A16, 1'b0);
        res1 = mk_res(wrap_addr(bases.ascii16, ascii16_off(code_low)),
                      gfra_pkg::CNT_A16, 1'b1);
      end else begin
        res0 = invalid_res;
      end
    end
  end

endmodule

>>> src/gb2312_font_rom_address_top.sv
// Channel  Direction  Handshake             Carries
// in_      input      in_valid / in_stall   action, code_high, code_low
// out_     output     out_valid / out_stall rom_address, byte_count, valid_res, last
// cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data (table base addresses)
//
// One request per cycle while in_stall is low; an unmapped GB2312 code that
// falls back to two ASCII glyph reads holds the input register until the
// second read is loaded. Path: input register, address logic, result register.
// rst_n is synchronous; it clears the valid flags and all base registers to 0.
// out_stall holds the result register; the input register still takes a
// request; in_stall rises once that one is held too, or for a fallback pair.
`include "gb2312_font_rom_address_top_defines.svh"

module gb2312_font_rom_address_top #(
  parameter int unsigned ADDRESS_BITS = gfra_pkg::ADDRESS_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [gfra_pkg::ACTION_W-1:0]      in_action,
  input  logic [gfra_pkg::CODE_W-1:0]        in_code_high,
  input  logic [gfra_pkg::CODE_W-1:0]        in_code_low,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [gfra_pkg::ADDR_W-1:0]        out_rom_address,
  output logic [gfra_pkg::COUNT_W-1:0]       out_byte_count,
  output logic                               out_valid_res,
  output logic                               out_last,
  // configuration
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gfra_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [gfra_pkg::ADDR_W-1:0]        cfg_data
);

  gfra_pkg::bases_t bases;
  gfra_pkg::res_t   res0;
  gfra_pkg::res_t   res1;
  logic             two;

  logic                          s1_valid_r, s1_valid_nxt;
  logic                          phase_r, phase_nxt;
  logic [gfra_pkg::ACTION_W-1:0] s1_action_r;
  logic [gfra_pkg::CODE_W-1:0]   s1_hi_r;
  logic [gfra_pkg::CODE_W-1:0]   s1_lo_r;
  logic                          out_valid_r, out_valid_nxt;
  gfra_pkg::res_t                out_res_r;

  logic out_load;
  logic s1_done;
  logic in_xfer;

  // Configuration registers
  assign cfg_ready = 1'b1;

  gfra_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_valid && cfg_ready),
    .wr_idx  (cfg_index),
    .wr_data (cfg_data),
    .bases   (bases)
  );

  // Address logic between the two registers
  gfra_addr_calc #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_calc (
    .action    (s1_action_r),
    .code_high (s1_hi_r),
    .code_low  (s1_lo_r),
    .bases     (bases),
    .res0      (res0),
    .res1      (res1),
    .two       (two)
  );

  // Flow control
  assign out_load = !out_valid_r || !out_stall;
  assign s1_done  = s1_valid_r && out_load && (!two || phase_r);
  assign in_stall = s1_valid_r && !s1_done;
  assign in_xfer  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_done) begin
      s1_valid_nxt = 1'b0;
    end

    phase_nxt = phase_r;
    if (s1_done) begin
      phase_nxt = 1'b0;
    end else if (s1_valid_r && out_load && two) begin
      phase_nxt = 1'b1;
    end

    out_valid_nxt = out_load ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_action_r <= in_action;
      s1_hi_r     <= in_code_high;
      s1_lo_r     <= in_code_low;
    end
    if (out_load && s1_valid_r) begin
      out_res_r <= phase_r ? res1 : res0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rom_address = out_res_r.rom_address;
  assign out_byte_count  = out_res_r.byte_count;
  assign out_valid_res   = out_res_r.valid_res;
  assign out_last        = out_res_r.last;

  // Checks
  `GFRA_ASSERT_NOW(a_phase_needs_item, phase_r, s1_valid_r,
    "second half pending with no request held")
  `GFRA_ASSERT_NOW(a_invalid_is_last, out_valid_r && !out_res_r.valid_res,
    out_res_r.last && (out_res_r.byte_count == gfra_pkg::CNT_NONE),
    "invalid result not final or has a length")
  `GFRA_ASSERT_NEXT(a_pair_follows, out_valid_r && !out_stall && !out_res_r.last,
    out_valid_r && out_res_r.last, "second fallback read did not follow")
  `GFRA_ASSERT_NOW(a_stall_when_full, in_stall, s1_valid_r && (out_valid_r || two),
    "input stalled while a stage is free")

endmodule
